/* sv/imdpe_pkg.sv */
// ----------------------------------------------------------------------------
// imdpe_pkg
// Shared types and constants of the int8 matrix dot-product engine.
// ----------------------------------------------------------------------------
package imdpe_pkg;

    localparam int LANES      = 16;
    localparam int GROUP      = 4;
    localparam int QUADS      = LANES / GROUP;
    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 64;
    localparam int PROD_W     = 2 * BYTE_W;
    localparam int QUAD_W     = PROD_W + 2;
    localparam int SUM_W      = PROD_W + 4;
    localparam int ACC_W      = 32;
    localparam int ADDR_W     = 16;
    localparam int BANK_W     = 3;
    localparam int DIM_W      = 9;
    localparam int CFG_AW     = 3;
    localparam int CFG_DW     = 9;
    localparam int QDEPTH     = 4;
    localparam int MAX_DIM_DF = 256;

    localparam logic [CFG_AW-1:0] REG_M_ROWS      = CFG_AW'(0);
    localparam logic [CFG_AW-1:0] REG_N_COLS      = CFG_AW'(1);
    localparam logic [CFG_AW-1:0] REG_K_CHUNKS    = CFG_AW'(2);
    localparam logic [CFG_AW-1:0] REG_RESULT_BANK = CFG_AW'(3);

    localparam logic [DIM_W-1:0]  DIM_RESET  = DIM_W'(1);
    localparam logic [BANK_W-1:0] BANK_RESET = '0;

    typedef struct packed {
        logic [DIM_W-1:0]  m_rows;
        logic [DIM_W-1:0]  n_cols;
        logic [DIM_W-1:0]  k_chunks;
        logic [BANK_W-1:0] result_bank;
    } t_cfg;

    typedef struct packed {
        logic                    start_run;
        logic signed [SUM_W-1:0] lane_sum;
    } t_q_entry;

    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_status;

endpackage

/* sv/imdpe_if.sv */
// ----------------------------------------------------------------------------
// imdpe interfaces
// Valid/ready channels for chunks, results and register writes.
// ----------------------------------------------------------------------------
interface imdpe_in_if;
    logic                            valid;
    logic                            ready;
    logic                            start_run;
    logic [imdpe_pkg::WORD_W-1:0]    a_low;
    logic [imdpe_pkg::WORD_W-1:0]    a_high;
    logic [imdpe_pkg::WORD_W-1:0]    b_low;
    logic [imdpe_pkg::WORD_W-1:0]    b_high;

    modport source (output valid, start_run, a_low, a_high, b_low, b_high, input ready);
    modport sink   (input valid, start_run, a_low, a_high, b_low, b_high, output ready);
endinterface

interface imdpe_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [imdpe_pkg::ACC_W-1:0]  dot_value;
    logic [imdpe_pkg::ADDR_W-1:0]        element_addr;
    logic [imdpe_pkg::BANK_W-1:0]        bank_out;
    logic                                run_last;

    modport source (output valid, dot_value, element_addr, bank_out, run_last, input ready);
    modport sink   (input valid, dot_value, element_addr, bank_out, run_last, output ready);
endinterface

interface imdpe_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [imdpe_pkg::CFG_AW-1:0] addr;
    logic [imdpe_pkg::CFG_DW-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

/* sv/imdpe_front.sv */
// ----------------------------------------------------------------------------
// imdpe_front
// Accepts chunks, forms the sixteen lane products and reduces them to one
// lane sum over three elastic stages, then pushes it to the queue.
// ----------------------------------------------------------------------------
module imdpe_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    imdpe_in_if.sink             i_in,
    input  imdpe_pkg::t_q_status i_qstat,
    output logic                 o_push,
    output imdpe_pkg::t_q_entry  o_entry
);
    import imdpe_pkg::*;

    logic                     r_v1, r_v2, r_v3;
    logic                     r_st1, r_st2, r_st3;
    logic signed [PROD_W-1:0] r_prod [LANES];
    logic signed [QUAD_W-1:0] r_quad [QUADS];
    logic signed [SUM_W-1:0]  r_sum;

    logic signed [PROD_W-1:0] n_prod [LANES];
    logic signed [QUAD_W-1:0] n_quad [QUADS];
    logic signed [SUM_W-1:0]  n_sum;

    logic [2*WORD_W-1:0] w_a, w_b;
    logic                w_adv1, w_adv2, w_adv3;

    assign w_adv3     = !r_v3 || !i_qstat.full;
    assign w_adv2     = !r_v2 || w_adv3;
    assign w_adv1     = !r_v1 || w_adv2;
    assign i_in.ready = w_adv1;
    assign o_push     = r_v3 && !i_qstat.full;

    assign w_a = {i_in.a_high, i_in.a_low};
    assign w_b = {i_in.b_high, i_in.b_low};

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            n_prod[i] = $signed(w_a[BYTE_W*i +: BYTE_W]) * $signed(w_b[BYTE_W*i +: BYTE_W]);
        end
        for (int q = 0; q < QUADS; q++) begin
            n_quad[q] = '0;
            for (int j = 0; j < GROUP; j++) begin
                n_quad[q] = n_quad[q] + QUAD_W'(r_prod[GROUP*q + j]);
            end
        end
        n_sum = '0;
        for (int q = 0; q < QUADS; q++) begin
            n_sum = n_sum + SUM_W'(r_quad[q]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_v1 <= i_in.valid;
            end
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
            if (w_adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_st1  <= i_in.start_run;
            r_prod <= n_prod;
        end
        if (w_adv2) begin
            r_st2  <= r_st1;
            r_quad <= n_quad;
        end
        if (w_adv3) begin
            r_st3 <= r_st2;
            r_sum <= n_sum;
        end
    end

    assign o_entry.start_run = r_st3;
    assign o_entry.lane_sum  = r_sum;

endmodule

/* sv/imdpe_queue.sv */
// ----------------------------------------------------------------------------
// imdpe_queue
// Small register FIFO of lane sums between the front and the back.
// ----------------------------------------------------------------------------
module imdpe_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  imdpe_pkg::t_q_entry  i_entry,
    input  logic                 i_pop,
    output imdpe_pkg::t_q_entry  o_head,
    output imdpe_pkg::t_q_status o_stat
);
    import imdpe_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    t_q_entry         r_mem [QDEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_head           = r_mem[r_rd];
    assign o_stat.full      = (r_cnt == CNT_W'(QDEPTH));
    assign o_stat.not_empty = (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

/* sv/imdpe_back.sv */
// ----------------------------------------------------------------------------
// imdpe_back
// Accumulates lane sums, walks the chunk, column and row counters and
// registers each finished element for the result channel.
// ----------------------------------------------------------------------------
module imdpe_back #(
    parameter int MAX_DIM = imdpe_pkg::MAX_DIM_DF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  imdpe_pkg::t_cfg      i_cfg,
    input  imdpe_pkg::t_q_entry  i_head,
    input  imdpe_pkg::t_q_status i_qstat,
    output logic                 o_pop,
    imdpe_out_if.source          o_out
);
    import imdpe_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int EW    = (DIM_W > $clog2(MAX_DIM + 1)) ? DIM_W : $clog2(MAX_DIM + 1);
    localparam int MW    = (CNT_W + EW + 1 > ADDR_W) ? CNT_W + EW + 1 : ADDR_W;

    function automatic logic [EW-1:0] f_eff(input logic [DIM_W-1:0] v);
        logic [EW-1:0] x;
        x = EW'(v);
        if (x == '0) begin
            return EW'(1);
        end else if (x > EW'(MAX_DIM)) begin
            return EW'(MAX_DIM);
        end
        return x;
    endfunction

    logic [ACC_W-1:0] r_acc;
    logic [CNT_W-1:0] r_chunk, r_row, r_col;
    logic             r_out_v;
    logic [ACC_W-1:0] r_dot;
    logic [ADDR_W-1:0] r_addr;
    logic [BANK_W-1:0] r_bank;
    logic              r_last;

    logic [EW-1:0]    w_m, w_n, w_k;
    logic [ACC_W-1:0] w_acc_base;
    logic [CNT_W-1:0] w_chunk_base, w_row_base, w_col_base;
    logic [EW-1:0]    w_chunk_inc, w_col_inc, w_row_inc;
    logic [MW-1:0]    w_addr;
    logic             w_emit, w_last;

    logic [ACC_W-1:0] n_acc;
    logic [CNT_W-1:0] n_chunk, n_row, n_col;

    assign w_m = f_eff(i_cfg.m_rows);
    assign w_n = f_eff(i_cfg.n_cols);
    assign w_k = f_eff(i_cfg.k_chunks);

    assign o_pop = i_qstat.not_empty && (!r_out_v || o_out.ready);

    always_comb begin
        w_acc_base   = i_head.start_run ? '0 : r_acc;
        w_chunk_base = i_head.start_run ? '0 : r_chunk;
        w_row_base   = i_head.start_run ? '0 : r_row;
        w_col_base   = i_head.start_run ? '0 : r_col;

        n_acc       = w_acc_base + ACC_W'($signed(i_head.lane_sum));
        w_chunk_inc = EW'(w_chunk_base) + EW'(1);
        w_col_inc   = EW'(w_col_base) + EW'(1);
        w_row_inc   = EW'(w_row_base) + EW'(1);
        w_emit      = (w_chunk_inc >= w_k);
        w_last      = (EW'(w_row_base) == w_m - EW'(1)) && (EW'(w_col_base) == w_n - EW'(1));
        w_addr      = MW'(w_row_base) * MW'(w_n) + MW'(w_col_base);

        n_chunk = w_chunk_inc[CNT_W-1:0];
        n_row   = w_row_base;
        n_col   = w_col_base;
        if (w_emit) begin
            n_chunk = '0;
            if (w_col_inc >= w_n) begin
                n_col = '0;
                n_row = (w_row_inc >= w_m) ? '0 : w_row_inc[CNT_W-1:0];
            end else begin
                n_col = w_col_inc[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_chunk <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (o_pop) begin
                r_acc   <= w_emit ? '0 : n_acc;
                r_chunk <= n_chunk;
                r_row   <= n_row;
                r_col   <= n_col;
            end
            if (o_pop && w_emit) begin
                r_out_v <= 1'b1;
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_emit) begin
            r_dot  <= n_acc;
            r_addr <= w_addr[ADDR_W-1:0];
            r_bank <= i_cfg.result_bank;
            r_last <= w_last;
        end
    end

    assign o_out.valid        = r_out_v;
    assign o_out.dot_value    = $signed(r_dot);
    assign o_out.element_addr = r_addr;
    assign o_out.bank_out     = r_bank;
    assign o_out.run_last     = r_last;

endmodule

/* sv/int8_matrix_dot_product_engine.sv */
// ----------------------------------------------------------------------------
// int8_matrix_dot_product_engine
// Top level: register file, product front, lane-sum queue, accumulator back.
// ----------------------------------------------------------------------------
// The engine takes one chunk of sixteen signed byte pairs per clock cycle,
// unless the queue is full, and emits one 32-bit wrapping dot product every
// k_chunks chunks, tagged with its row-major address, the result bank and a
// flag on the last element of the matrix. A chunk passes the three elastic
// stages of the product and adder-tree front and a four-entry queue and is
// accumulated in the back in the same cycle it leaves the queue; the finished
// element is registered for the result channel. The accumulate and counter
// update in the back set the rate of one chunk per cycle while results
// drain; the queue lets the front keep taking chunks until it fills while
// the result channel stalls. Registers are to be written only while the
// engine is idle; the engine does not check it. A write is taken every cycle.
// ----------------------------------------------------------------------------
module int8_matrix_dot_product_engine #(
    parameter int MAX_DIM = imdpe_pkg::MAX_DIM_DF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    imdpe_in_if.sink    i_in,
    imdpe_cfg_if.sink   i_cfg,
    imdpe_out_if.source o_out
);
    import imdpe_pkg::*;

    t_cfg      r_cfg;
    t_q_entry  w_entry, w_head;
    t_q_status w_qstat;
    logic      w_push, w_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.m_rows      <= DIM_RESET;
            r_cfg.n_cols      <= DIM_RESET;
            r_cfg.k_chunks    <= DIM_RESET;
            r_cfg.result_bank <= BANK_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.addr)
                REG_M_ROWS:      r_cfg.m_rows      <= i_cfg.data[DIM_W-1:0];
                REG_N_COLS:      r_cfg.n_cols      <= i_cfg.data[DIM_W-1:0];
                REG_K_CHUNKS:    r_cfg.k_chunks    <= i_cfg.data[DIM_W-1:0];
                REG_RESULT_BANK: r_cfg.result_bank <= i_cfg.data[BANK_W-1:0];
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    imdpe_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_qstat (w_qstat),
        .o_push  (w_push),
        .o_entry (w_entry)
    );

    imdpe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_qstat)
    );

    imdpe_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_head  (w_head),
        .i_qstat (w_qstat),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_qstat.full))
        else $error("lane-sum queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_qstat.not_empty)
        else $error("lane-sum queue read while empty");

    a_pop_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && o_out.valid) |-> o_out.ready)
        else $error("back advanced while a result was stalled");

endmodule

/* test/int8_matrix_dot_product_engine_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// int8_matrix_dot_product_engine_test
// Self-checking testbench for the int8 matrix dot-product engine.
// ----------------------------------------------------------------------------
// Chunks of sixteen signed byte pairs are streamed into the engine while the
// result channel stalls at random. Every accepted chunk is folded into a local
// copy of the accumulator and the row/column/chunk counters. Each finished
// element is queued as an expected result and compared field by field with
// what the engine emits. Directed tests cover extreme lane values, register
// defaults, writes to unused indexes, restarts inside an element, clamped
// dimensions, the longest inner dimension, resizing between elements and a
// long output stall. Random phases with varied shapes follow.
// ----------------------------------------------------------------------------
module int8_matrix_dot_product_engine_test;
    import imdpe_pkg::*;

    localparam int MAX_DIM       = MAX_DIM_DF;
    localparam int IDLE_PCT      = 37;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_ITEMS  = 900;
    localparam int CYCLE_LIMIT   = 400000;

    localparam logic [WORD_W-1:0] LANES_MIN  = {8{8'h80}};
    localparam logic [WORD_W-1:0] LANES_MAX  = {8{8'h7F}};
    localparam logic [WORD_W-1:0] LANES_NEG1 = {8{8'hFF}};
    localparam logic [WORD_W-1:0] LANES_ALT  = {4{16'h01FF}};

    typedef struct packed {
        logic signed [ACC_W-1:0] dot_value;
        logic [ADDR_W-1:0]       element_addr;
        logic [BANK_W-1:0]       bank;
        logic                    run_last;
    } dot_result_t;

    logic clk = 1'b0;
    logic rst_n;

    imdpe_in_if  in_ch ();
    imdpe_out_if out_ch ();
    imdpe_cfg_if cfg_ch ();

    int8_matrix_dot_product_engine DUT (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch.sink),
        .i_cfg  (cfg_ch.sink),
        .o_out  (out_ch.source)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Local copy of the registers and the element counters
    logic [DIM_W-1:0]  dim_m    = DIM_RESET;
    logic [DIM_W-1:0]  dim_n    = DIM_RESET;
    logic [DIM_W-1:0]  dim_k    = DIM_RESET;
    logic [BANK_W-1:0] bank_sel = BANK_RESET;
    logic [ACC_W-1:0]  acc_model = '0;
    int unsigned       row_idx   = 0;
    int unsigned       col_idx   = 0;
    int unsigned       chunk_idx = 0;

    dot_result_t expected_dots[$];

    int errors       = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int config_count = 0;
    int cycle_count  = 0;
    int in_idle_pct  = IDLE_PCT;
    int out_idle_pct = IDLE_PCT;
    int hold_asked   = 0;
    int hold_taken   = 0;
    int hold_left    = 0;

    function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return v;
    endfunction

    function automatic logic [WORD_W-1:0] pick_lanes();
        case ($urandom_range(7))
            0: return LANES_MIN;
            1: return LANES_MAX;
            2: return '0;
            3: return LANES_NEG1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(15))
            0: return '0;
            1: return DIM_W'(MAX_DIM);
            2: return DIM_W'($urandom_range(MAX_DIM + 1, 2**DIM_W - 1));
            default: return DIM_W'($urandom_range(1, 4));
        endcase
    endfunction

    task automatic fold_chunk(input logic start, input logic [WORD_W-1:0] al, ah, bl, bh);
        logic [2*WORD_W-1:0] a_vec;
        logic [2*WORD_W-1:0] b_vec;
        byte signed av;
        byte signed bv;
        int chunk_sum;
        int unsigned m_eff;
        int unsigned n_eff;
        int unsigned k_eff;
        dot_result_t res;
        a_vec = {ah, al};
        b_vec = {bh, bl};
        m_eff = clamp_dim(dim_m);
        n_eff = clamp_dim(dim_n);
        k_eff = clamp_dim(dim_k);
        if (start) begin
            acc_model = '0;
            row_idx   = 0;
            col_idx   = 0;
            chunk_idx = 0;
        end
        chunk_sum = 0;
        for (int i = 0; i < LANES; i++) begin
            av = a_vec[8*i +: 8];
            bv = b_vec[8*i +: 8];
            chunk_sum += int'(av) * int'(bv);
        end
        acc_model = acc_model + chunk_sum;
        chunk_idx++;
        if (chunk_idx >= k_eff) begin
            res.dot_value    = acc_model;
            res.element_addr = ADDR_W'(row_idx * n_eff + col_idx);
            res.bank         = bank_sel;
            res.run_last     = (row_idx == m_eff - 1) && (col_idx == n_eff - 1);
            expected_dots.push_back(res);
            acc_model = '0;
            chunk_idx = 0;
            col_idx++;
            if (col_idx >= n_eff) begin
                col_idx = 0;
                row_idx++;
                if (row_idx >= m_eff) row_idx = 0;
            end
        end
    endtask

    task automatic send_chunk(input logic start, input logic [WORD_W-1:0] al, ah, bl, bh);
        while ($urandom_range(99) < in_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.start_run <= start;
        in_ch.a_low     <= al;
        in_ch.a_high    <= ah;
        in_ch.b_low     <= bl;
        in_ch.b_high    <= bh;
        do @(posedge clk); while (!in_ch.ready);
        fold_chunk(start, al, ah, bl, bh);
        items_sent++;
    endtask

    task automatic send_random(input int count, input logic first_start);
        for (int i = 0; i < count; i++) begin
            send_chunk((i == 0) && first_start, pick_lanes(), pick_lanes(),
                       pick_lanes(), pick_lanes());
        end
    endtask

    // Leaves valid high so back-to-back writes keep one assignment per step
    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            REG_M_ROWS:      dim_m    = value;
            REG_N_COLS:      dim_n    = value;
            REG_K_CHUNKS:    dim_k    = value;
            REG_RESULT_BANK: bank_sel = value[BANK_W-1:0];
            default: ;
        endcase
    endtask

    task automatic close_writes();
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic configure(input logic [DIM_W-1:0] m, n, k, input logic [BANK_W-1:0] bank);
        write_reg(REG_M_ROWS, m);
        write_reg(REG_N_COLS, n);
        write_reg(REG_K_CHUNKS, k);
        write_reg(REG_RESULT_BANK, CFG_DW'(bank));
        close_writes();
        config_count++;
    endtask

    // Drain every pending result, then let chunks with no result clear the pipe
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (expected_dots.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_reset_defaults();
        send_chunk(1'b1, LANES_MIN, LANES_MIN, LANES_MIN, LANES_MIN);
        send_chunk(1'b0, LANES_MAX, LANES_MAX, LANES_MIN, LANES_MIN);
        send_chunk(1'b0, LANES_MAX, LANES_MAX, LANES_MAX, LANES_MAX);
        send_chunk(1'b1, LANES_ALT, LANES_NEG1, LANES_MIN, LANES_ALT);
    endtask

    task automatic test_register_map();
        wait_idle();
        for (int idx = REG_RESULT_BANK + 1; idx < 2**CFG_AW; idx++) begin
            write_reg(CFG_AW'(idx), '1);
        end
        configure(2, 2, 2, 3'd7);
        send_random(8, 1'b0);
    endtask

    task automatic test_restart_mid_element();
        wait_idle();
        configure(1, 2, 3, 3'd5);
        send_random(2, 1'b0);
        send_random(3, 1'b1);
        send_random(1, 1'b0);
        send_random(3, 1'b1);
    endtask

    task automatic test_dimension_clamp();
        wait_idle();
        configure('0, '1, '0, 3'd2);
        send_random(MAX_DIM + 2, 1'b1);
    endtask

    task automatic test_longest_inner();
        wait_idle();
        configure(1, 1, DIM_W'(MAX_DIM), 3'd3);
        send_random(MAX_DIM, 1'b1);
    endtask

    task automatic test_resize_mid_run();
        wait_idle();
        configure(DIM_W'(300), 1, 1, 3'd4);
        send_random(200, 1'b1);
        wait_idle();
        write_reg(REG_N_COLS, CFG_DW'(MAX_DIM));
        close_writes();
        send_random(20, 1'b0);
        wait_idle();
        write_reg(REG_N_COLS, 5);
        close_writes();
        send_random(10, 1'b0);
        wait_idle();
        write_reg(REG_K_CHUNKS, 8);
        close_writes();
        send_random(5, 1'b0);
        wait_idle();
        write_reg(REG_K_CHUNKS, 2);
        close_writes();
        send_random(5, 1'b0);
        wait_idle();
        write_reg(REG_M_ROWS, 0);
        close_writes();
        send_random(10, 1'b0);
    endtask

    task automatic test_output_backpressure();
        wait_idle();
        configure(4, 4, 1, 3'd6);
        in_idle_pct = 0;
        hold_asked <= hold_asked + 1;
        send_random(150, 1'b1);
        in_idle_pct = IDLE_PCT;
    endtask

    task automatic test_random_runs();
        int unsigned span;
        int count;
        int phase;
        int random_items;
        bit quiet;
        phase = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            wait_idle();
            quiet = (phase >= 6) && (phase < 16);
            in_idle_pct = quiet ? 0 : IDLE_PCT;
            out_idle_pct <= quiet ? 0 : IDLE_PCT;
            if ($urandom_range(3) == 0) begin
                write_reg(CFG_AW'($urandom_range(REG_RESULT_BANK + 1, 2**CFG_AW - 1)),
                          CFG_DW'($urandom));
            end
            configure(pick_dim(), pick_dim(), pick_dim(), BANK_W'($urandom_range(7)));
            span  = clamp_dim(dim_m) * clamp_dim(dim_n) * clamp_dim(dim_k);
            count = span * $urandom_range(1, 2) + $urandom_range(0, 3);
            if (count > 60) count = $urandom_range(20, 60);
            for (int i = 0; i < count; i++) begin
                send_chunk((i == 0) ? ($urandom_range(2) == 0) : ($urandom_range(39) == 0),
                           pick_lanes(), pick_lanes(), pick_lanes(), pick_lanes());
            end
            random_items += count;
            phase++;
        end
        in_idle_pct = IDLE_PCT;
        out_idle_pct <= IDLE_PCT;
    endtask

    always @(posedge clk) begin
        if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (hold_taken != hold_asked) begin
            hold_taken   <= hold_asked;
            hold_left    <= HOLD_CYCLES - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    always @(posedge clk) begin : check_dots
        dot_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            results_seen++;
            if (expected_dots.size() == 0) begin
                $display("%0t: result with none pending, value %0d addr %0d", $time,
                         out_ch.dot_value, out_ch.element_addr);
                errors++;
            end else begin
                want = expected_dots.pop_front();
                if (out_ch.dot_value !== want.dot_value) begin
                    $display("%0t: dot_value expected %0d, actual %0d", $time,
                             want.dot_value, out_ch.dot_value);
                    errors++;
                end
                if (out_ch.element_addr !== want.element_addr) begin
                    $display("%0t: element_addr expected %0d, actual %0d", $time,
                             want.element_addr, out_ch.element_addr);
                    errors++;
                end
                if (out_ch.bank_out !== want.bank) begin
                    $display("%0t: bank_out expected %0d, actual %0d", $time,
                             want.bank, out_ch.bank_out);
                    errors++;
                end
                if (out_ch.run_last !== want.run_last) begin
                    $display("%0t: run_last expected %0b, actual %0b", $time,
                             want.run_last, out_ch.run_last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results pending", $time, expected_dots.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.start_run = 1'b0;
        in_ch.a_low     = '0;
        in_ch.a_high    = '0;
        in_ch.b_low     = '0;
        in_ch.b_high    = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.addr     = '0;
        cfg_ch.data     = '0;
        out_ch.ready    = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_register_map();
        test_restart_mid_element();
        test_dimension_clamp();
        test_longest_inner();
        test_resize_mid_run();
        test_output_backpressure();
        test_random_runs();
        wait_idle();

        $display("Run covered %0d chunks, %0d results, %0d register settings.",
                 items_sent, results_seen, config_count);
        $display("Included clamped sizes, restarts, resizes and a %0d-cycle output stall.",
                 HOLD_CYCLES);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
